// File: src/cpfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfc_pkg
// shared types and constants of the camera pixel format converter
// ----------------------------------------------------------------------------
package cpfc_pkg;

  localparam logic [1:0] FMT_RGB32 = 2'd0;
  localparam logic [1:0] FMT_Y16   = 2'd1;
  localparam logic [1:0] FMT_YUY2  = 2'd2;
  localparam logic [1:0] FMT_NV12  = 2'd3;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_MIRROR = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam int CFG_DATA_W = 13;
  localparam int IDX_W      = 24;

  // one classified pair handed from the front part to the back part
  typedef struct packed {
    logic [1:0]  fmt;
    logic [IDX_W-1:0] idx0;
    logic [IDX_W-1:0] idx1;
    logic        last;
    logic [15:0] luma0;
    logic [15:0] luma1;
    logic [7:0]  cb;
    logic [7:0]  cr;
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
    logic [15:0] smin;
    logic [15:0] srange;
  } cpfc_job_t;

  // one output pixel
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  sr;
    logic [7:0]  sg;
    logic [7:0]  sb;
    logic [15:0] samp;
    logic        last;
  } cpfc_pix_t;

  function automatic logic [7:0] clamp255(input logic signed [11:0] v);
    if (v < 0) return 8'd0;
    if (v > 12'sd255) return 8'd255;
    return v[7:0];
  endfunction

endpackage

`default_nettype wire

// File: src/cpfc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfc_front
// accepts items, tracks raster position and y16 min/max, builds jobs
// ----------------------------------------------------------------------------
module cpfc_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [12:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic [15:0]          in_luma_first,
  input  wire logic [15:0]          in_luma_second,
  input  wire logic [7:0]           in_chroma_blue,
  input  wire logic [7:0]           in_chroma_red,
  input  wire logic [7:0]           in_red_first,
  input  wire logic [7:0]           in_green_first,
  input  wire logic [7:0]           in_blue_first,
  input  wire logic [7:0]           in_red_second,
  input  wire logic [7:0]           in_green_second,
  input  wire logic [7:0]           in_blue_second,
  output logic                      job_valid,
  input  wire logic                 job_ready,
  output cpfc_pkg::cpfc_job_t       job
);
  import cpfc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam logic [13:0] MAXW_EVEN = 14'(MAX_WIDTH) & ~14'd1;
  localparam logic [13:0] MAXH = 14'(MAX_HEIGHT);

  logic [1:0]  fmt_r;
  logic        mirror_r;
  logic [12:0] width_r, height_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [15:0] smin_r, smax_r;
  logic        job_valid_r;
  cpfc_job_t   job_r;

  logic [13:0] w_e, h_e, w_tmp;
  logic [CW-1:0] col_c;
  logic [RW-1:0] row_c;
  logic [15:0] mn, mx, mn_nxt, mx_nxt;
  logic        accept, last_pair, wrap_col;
  logic [CW+1:0] col2;
  logic [IDX_W+1:0] base;
  logic [IDX_W-1:0] c0, c1;

  always_comb begin
    w_tmp = {1'b0, width_r & ~13'd1};
    if (w_tmp < 14'd2) w_tmp = 14'd2;
    if (w_tmp > MAXW_EVEN) w_tmp = MAXW_EVEN;
    w_e = w_tmp;
    h_e = {1'b0, height_r};
    if (h_e < 14'd1) h_e = 14'd1;
    if (h_e > MAXH) h_e = MAXH;
    col_c = (14'(col_r) >= w_e) ? '0 : col_r;
    row_c = (14'(row_r) >= h_e) ? '0 : row_r;
    col2 = (CW+2)'(col_c) + (CW+2)'(2);
    wrap_col = 14'(col2) >= w_e;
    last_pair = wrap_col && (14'(row_c) + 14'd1 >= h_e);
    base = (IDX_W+2)'(row_c) * (IDX_W+2)'(w_e);
    if (mirror_r) begin
      c0 = IDX_W'(w_e) - IDX_W'(1) - IDX_W'(col_c);
      c1 = c0 - IDX_W'(1);
    end else begin
      c0 = IDX_W'(col_c);
      c1 = c0 + IDX_W'(1);
    end
    mn = (col_c == '0 && row_c == '0) ? 16'hFFFF : smin_r;
    mx = (col_c == '0 && row_c == '0) ? 16'h0000 : smax_r;
    mn_nxt = mn;
    mx_nxt = mx;
    if (in_luma_first < mn_nxt) mn_nxt = in_luma_first;
    if (in_luma_first > mx_nxt) mx_nxt = in_luma_first;
    if (in_luma_second < mn_nxt) mn_nxt = in_luma_second;
    if (in_luma_second > mx_nxt) mx_nxt = in_luma_second;
  end

  assign in_ready = !job_valid_r || job_ready;
  assign accept = in_valid && in_ready;
  assign job_valid = job_valid_r;
  assign job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGB32;
      mirror_r <= 1'b0;
      width_r <= 13'd640;
      height_r <= 13'd480;
      col_r <= '0;
      row_r <= '0;
      smin_r <= 16'hFFFF;
      smax_r <= 16'h0000;
      job_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FORMAT: fmt_r <= cfg_data[1:0];
          REG_MIRROR: mirror_r <= cfg_data[0];
          REG_WIDTH:  width_r <= cfg_data;
          REG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (job_ready) job_valid_r <= 1'b0;
      if (accept) begin
        if (wrap_col) begin
          col_r <= '0;
          row_r <= (14'(row_c) + 14'd1 >= h_e) ? '0 : row_c + RW'(1);
        end else begin
          col_r <= col2[CW-1:0];
          row_r <= row_c;
        end
        if (!in_req_type) begin
          smin_r <= mn_nxt;
          smax_r <= mx_nxt;
        end else begin
          job_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_req_type) begin
      job_r.fmt <= fmt_r;
      job_r.idx0 <= base[IDX_W-1:0] + c0;
      job_r.idx1 <= base[IDX_W-1:0] + c1;
      job_r.last <= last_pair;
      job_r.luma0 <= in_luma_first;
      job_r.luma1 <= in_luma_second;
      job_r.cb <= in_chroma_blue;
      job_r.cr <= in_chroma_red;
      job_r.r0 <= in_red_first;
      job_r.g0 <= in_green_first;
      job_r.b0 <= in_blue_first;
      job_r.r1 <= in_red_second;
      job_r.g1 <= in_green_second;
      job_r.b1 <= in_blue_second;
      job_r.smin <= smin_r;
      job_r.srange <= (smax_r > smin_r) ? smax_r - smin_r : 16'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_job_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_req_type && !job_valid) |=> !job_valid)
    else $error("scan item produced a job");
  a_hold_job: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && !job_ready) |=> job_valid && $stable(job))
    else $error("job dropped while stalled");
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_req_type) |=> smin_r <= smax_r)
    else $error("min above max after scan");
`endif

endmodule

`default_nettype wire

// File: src/cpfc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfc_div
// restoring divider, one quotient bit per cycle, 24 by 16 bits
// ----------------------------------------------------------------------------
module cpfc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [23:0] num,
  input  wire logic [15:0] den,
  output logic             done,
  output logic [23:0]      quo
);
  logic [23:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt, trial;
  logic [15:0] den_r;
  logic [4:0]  cnt_r;
  logic        busy_r;

  always_comb begin
    trial = {rem_r[15:0], q_r[23]};
    q_nxt = {q_r[22:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  assign done = busy_r && cnt_r == 5'd0;
  assign quo = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 5'd24;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r && cnt_r != 5'd0) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/cpfc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpfc_back
// converts one job into two output pixels and emits them in order
// ----------------------------------------------------------------------------
module cpfc_back #(
  parameter int COEF_FRACTION_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                job_valid,
  output logic                     job_ready,
  input  wire cpfc_pkg::cpfc_job_t job,
  output logic                     pix_valid,
  input  wire logic                pix_ready,
  output cpfc_pkg::cpfc_pix_t      pix
);
  import cpfc_pkg::*;

  localparam int F = COEF_FRACTION_BITS;
  localparam int CW = F + 2;
  localparam logic [CW-1:0] COEF_RV =
    CW'((64'd1402 * (64'd1 << F) + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] COEF_GU =
    CW'((64'd344136 * (64'd1 << F) + 64'd500000) / 64'd1000000);
  localparam logic [CW-1:0] COEF_GV =
    CW'((64'd714136 * (64'd1 << F) + 64'd500000) / 64'd1000000);
  localparam logic [CW-1:0] COEF_BU =
    CW'((64'd1772 * (64'd1 << F) + 64'd500) / 64'd1000);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_OUT0, ST_OUT1
  } state_t;

  state_t    state_r;
  cpfc_job_t job_r;
  logic      k_r;
  logic signed [9:0] crv_r, cgu_r, cgv_r, cbu_r;
  logic [7:0] gray_r;
  logic      div_done;
  logic [23:0] div_q;
  cpfc_pix_t pix_r;

  logic [8:0]  dm, em;
  logic        dn, en;
  logic [CW+8:0] prv, pgu, pgv, pbu;
  logic [15:0] s;
  logic [23:0] num;

  assign dn = job_r.cb < 8'd128;
  assign en = job_r.cr < 8'd128;
  assign dm = dn ? 9'd128 - {1'b0, job_r.cb} : {1'b0, job_r.cb} - 9'd128;
  assign em = en ? 9'd128 - {1'b0, job_r.cr} : {1'b0, job_r.cr} - 9'd128;
  assign prv = (CW+9)'(em) * (CW+9)'(COEF_RV);
  assign pgu = (CW+9)'(dm) * (CW+9)'(COEF_GU);
  assign pgv = (CW+9)'(em) * (CW+9)'(COEF_GV);
  assign pbu = (CW+9)'(dm) * (CW+9)'(COEF_BU);
  assign s = k_r ? job_r.luma1 : job_r.luma0;
  assign num = 24'(s - job_r.smin) * 24'd255;

  logic run_div_r;
  cpfc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(run_div_r), .num(num), .den(job_r.srange),
    .done(div_done), .quo(div_q)
  );

  logic [7:0] y8;
  logic signed [11:0] yv;
  always_comb begin
    y8 = k_r ? job_r.luma1[7:0] : job_r.luma0[7:0];
    yv = 12'(y8);
    pix = pix_r;
  end

  assign job_ready = (state_r == ST_IDLE);
  assign pix_valid = (state_r == ST_OUT0) || (state_r == ST_OUT1);

  function automatic logic signed [9:0] sgn(input logic [CW+8:0] p, input logic neg);
    logic [9:0] m;
    m = 10'(p >> F);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r <= 1'b0;
      run_div_r <= 1'b0;
    end else begin
      run_div_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          k_r <= 1'b0;
          if (job_valid) begin
            job_r <= job;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          crv_r <= sgn(prv, en);
          cgu_r <= sgn(pgu, dn);
          cgv_r <= sgn(pgv, en);
          cbu_r <= sgn(pbu, dn);
          if (job_r.fmt == FMT_Y16) begin
            run_div_r <= 1'b1;
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_OUT0;
          end
        end
        ST_DIV: begin
          if (div_done && !run_div_r) begin
            if (s < job_r.smin) gray_r <= 8'd0;
            else gray_r <= (div_q > 24'd255) ? 8'd255 : div_q[7:0];
            state_r <= ST_OUT0;
          end
        end
        ST_OUT0, ST_OUT1: begin
          if (pix_ready) begin
            if (k_r) begin
              state_r <= ST_IDLE;
            end else begin
              k_r <= 1'b1;
              if (job_r.fmt == FMT_Y16) begin
                run_div_r <= 1'b1;
                state_r <= ST_DIV;
              end else begin
                state_r <= ST_OUT1;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    pix_r.idx = k_r ? job_r.idx1 : job_r.idx0;
    pix_r.last = k_r && job_r.last;
    pix_r.samp = 16'd0;
    case (job_r.fmt)
      FMT_RGB32: begin
        pix_r.r = k_r ? job_r.b1 : job_r.b0;
        pix_r.g = pix_r.r;
        pix_r.b = pix_r.r;
        pix_r.sr = k_r ? job_r.r1 : job_r.r0;
        pix_r.sg = k_r ? job_r.g1 : job_r.g0;
        pix_r.sb = pix_r.r;
      end
      FMT_Y16: begin
        pix_r.r = gray_r;
        pix_r.g = gray_r;
        pix_r.b = gray_r;
        pix_r.sr = gray_r;
        pix_r.sg = gray_r;
        pix_r.sb = gray_r;
        pix_r.samp = s;
      end
      default: begin
        pix_r.r = clamp255(yv + 12'(crv_r));
        pix_r.g = clamp255(yv - 12'(cgu_r) - 12'(cgv_r));
        pix_r.b = clamp255(yv + 12'(cbu_r));
        pix_r.sr = pix_r.r;
        pix_r.sg = pix_r.g;
        pix_r.sb = pix_r.b;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_last_second: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_valid && pix.last) |-> k_r)
    else $error("frame end flagged on first pixel");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_ready) |=> state_r == ST_MUL)
    else $error("job taken without starting");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_valid && !pix_ready) |=> pix_valid && $stable(pix))
    else $error("pixel changed while stalled");
`endif

endmodule

`default_nettype wire

// File: src/camera_pixel_format_converter.sv
`default_nettype none
// a convert item passes the front job register, then the back states MUL
// and OUT0 (yuv, rgb32), with state DIV before OUT0 in y16 mode, where
// a bit-serial divider runs; the back takes a job only when it is idle
// a one-deep job queue from front to back lets scan items flow while empty
// reset: synchronous active low, registers to defaults, min 65535, max 0
// ----------------------------------------------------------------------------
// camera_pixel_format_converter
// camera pixels to rgb preview and snapshot pixels, two per convert item
// ----------------------------------------------------------------------------
module camera_pixel_format_converter #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int COEF_FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [15:0] in_luma_first,
  input  wire logic [15:0] in_luma_second,
  input  wire logic [7:0]  in_chroma_blue,
  input  wire logic [7:0]  in_chroma_red,
  input  wire logic [7:0]  in_red_first,
  input  wire logic [7:0]  in_green_first,
  input  wire logic [7:0]  in_blue_first,
  input  wire logic [7:0]  in_red_second,
  input  wire logic [7:0]  in_green_second,
  input  wire logic [7:0]  in_blue_second,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [23:0]      out_pixel_index,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_snap_red,
  output logic [7:0]       out_snap_green,
  output logic [7:0]       out_snap_blue,
  output logic [15:0]      out_snap_sample,
  output logic             out_frame_last
);
  import cpfc_pkg::*;

  logic      job_valid, job_ready;
  cpfc_job_t job;
  cpfc_pix_t pix;

  cpfc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_luma_first(in_luma_first),
    .in_luma_second(in_luma_second), .in_chroma_blue(in_chroma_blue),
    .in_chroma_red(in_chroma_red), .in_red_first(in_red_first),
    .in_green_first(in_green_first), .in_blue_first(in_blue_first),
    .in_red_second(in_red_second), .in_green_second(in_green_second),
    .in_blue_second(in_blue_second), .job_valid(job_valid),
    .job_ready(job_ready), .job(job)
  );

  cpfc_back #(.COEF_FRACTION_BITS(COEF_FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .pix_valid(out_valid), .pix_ready(out_ready), .pix(pix)
  );

  assign out_pixel_index = pix.idx;
  assign out_red = pix.r;
  assign out_green = pix.g;
  assign out_blue = pix.b;
  assign out_snap_red = pix.sr;
  assign out_snap_green = pix.sg;
  assign out_snap_blue = pix.sb;
  assign out_snap_sample = pix.samp;
  assign out_frame_last = pix.last;

`ifndef NO_ASSERTIONS
  a_last_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_frame_last) |=> !(out_valid && out_frame_last))
    else $error("frame end repeated");
  a_gray_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_snap_sample != 16'd0) |-> (out_red == out_green))
    else $error("y16 pixel not gray");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> in_valid)
    else $error("input item withdrawn");
`endif

endmodule

`default_nettype wire

// File: test/camera_pixel_format_converter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_pixel_format_converter_tb
// Drives pixel pairs in all four source formats through the converter, with
// bursty input, random output stalls and one long output hold-off. Every
// pixel is checked against a cycle-free predictor of the conversion.
// ----------------------------------------------------------------------------
module camera_pixel_format_converter_tb;
  import cpfc_pkg::*;

  localparam longint COEF_RV = (1402 * 65536 + 500) / 1000;
  localparam longint COEF_GU = (344136 * 65536 + 500000) / 1000000;
  localparam longint COEF_GV = (714136 * 65536 + 500000) / 1000000;
  localparam longint COEF_BU = (1772 * 65536 + 500) / 1000;
  localparam int PHASE_ITEMS = 110;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic        req;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [7:0]  cb;
    logic [7:0]  cr;
    logic [7:0]  r0, g0, b0, r1, g1, b1;
  } pair_t;

  typedef struct {
    logic [1:0]  fmt;
    logic        mir;
    logic [12:0] w;
    logic [12:0] h;
    pair_t       p;
    bit          has_exp;
    logic [7:0]  ex0;
    logic [7:0]  ex1;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_FORMAT;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [15:0] in_luma_first = '0, in_luma_second = '0;
  logic [7:0] in_chroma_blue = '0, in_chroma_red = '0;
  logic [7:0] in_red_first = '0, in_green_first = '0, in_blue_first = '0;
  logic [7:0] in_red_second = '0, in_green_second = '0, in_blue_second = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] out_pixel_index;
  logic [7:0] out_red, out_green, out_blue;
  logic [7:0] out_snap_red, out_snap_green, out_snap_blue;
  logic [15:0] out_snap_sample;
  logic out_frame_last;

  camera_pixel_format_converter DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [1:0] p_fmt = FMT_RGB32;
  logic p_mir = 1'b0;
  int unsigned p_fw = 640, p_fh = 480;
  int unsigned p_col = 0, p_row = 0;
  int unsigned p_min = 65535, p_max = 0;
  cpfc_pix_t pixel_q[$];

  int errors = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  function automatic int unsigned active_width();
    int unsigned w;
    w = p_fw & ~32'd1;
    if (w < 2) w = 2;
    if (w > 4096) w = 4096;
    return w;
  endfunction

  function automatic int unsigned active_height();
    return (p_fh < 1) ? 1 : ((p_fh > 4096) ? 4096 : p_fh);
  endfunction

  function automatic int scaled(longint coef, int e);
    longint mag;
    mag = ((e < 0) ? -e : e) * coef;
    return (e < 0) ? -int'(mag >>> 16) : int'(mag >>> 16);
  endfunction

  function automatic logic [7:0] sat8(int v);
    return (v < 0) ? 8'd0 : ((v > 255) ? 8'd255 : v[7:0]);
  endfunction

  function automatic logic [7:0] gray_level(int unsigned s);
    int unsigned span, q;
    span = (p_max > p_min) ? p_max - p_min : 1;
    if (s < p_min) return 8'd0;
    q = ((s - p_min) * 255) / span;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // advances the position, tracks scan min/max, queues convert pixel pairs
  task automatic predict_pixels(input pair_t p);
    int unsigned w, h, col, dcol, lum;
    int d, e, y;
    bit last_pair;
    cpfc_pix_t px;
    logic [7:0] blu;
    w = active_width();
    h = active_height();
    if (p_col >= w) p_col = 0;
    if (p_row >= h) p_row = 0;
    d = int'(p.cb) - 128;
    e = int'(p.cr) - 128;
    last_pair = (p_col + 2 >= w) && (p_row + 1 >= h);
    if (!p.req) begin
      if (p_col == 0 && p_row == 0) begin
        p_min = 65535;
        p_max = 0;
      end
      if (p.y0 < p_min) p_min = p.y0;
      if (p.y0 > p_max) p_max = p.y0;
      if (p.y1 < p_min) p_min = p.y1;
      if (p.y1 > p_max) p_max = p.y1;
    end else begin
      for (int k = 0; k < 2; k++) begin
        col = p_col + k;
        dcol = p_mir ? (w - 1 - col) : col;
        lum = k ? p.y1 : p.y0;
        blu = k ? p.b1 : p.b0;
        px = '0;
        px.idx = IDX_W'(p_row * w + dcol);
        case (p_fmt)
          FMT_RGB32: begin
            px.r = blu; px.g = blu; px.b = blu;
            px.sr = k ? p.r1 : p.r0;
            px.sg = k ? p.g1 : p.g0;
            px.sb = blu;
          end
          FMT_Y16: begin
            px.r = gray_level(lum); px.g = px.r; px.b = px.r;
            px.sr = px.r; px.sg = px.r; px.sb = px.r;
            px.samp = lum[15:0];
          end
          default: begin
            y = lum & 255;
            px.r = sat8(y + scaled(COEF_RV, e));
            px.g = sat8(y - scaled(COEF_GU, d) - scaled(COEF_GV, e));
            px.b = sat8(y + scaled(COEF_BU, d));
            px.sr = px.r; px.sg = px.g; px.sb = px.b;
          end
        endcase
        px.last = (k == 1) && last_pair;
        pixel_q.push_back(px);
      end
    end
    p_col += 2;
    if (p_col >= w) begin
      p_col = 0;
      p_row++;
      if (p_row >= h) p_row = 0;
    end
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      REG_FORMAT: p_fmt = value[1:0];
      REG_MIRROR: p_mir = value[0];
      REG_WIDTH:  p_fw = value;
      default:    p_fh = value;
    endcase
  endtask

  task automatic set_mode(input logic [1:0] f, input logic m, input logic [12:0] w,
                          input logic [12:0] h);
    write_reg(REG_FORMAT, {11'd0, f});
    write_reg(REG_MIRROR, {12'd0, m});
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_pair(input pair_t p, input bit has_exp = 0,
                           input logic [7:0] ex0 = 0, input logic [7:0] ex1 = 0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid = 1'b1;
    in_req_type = p.req;
    in_luma_first = p.y0;
    in_luma_second = p.y1;
    in_chroma_blue = p.cb;
    in_chroma_red = p.cr;
    in_red_first = p.r0;
    in_green_first = p.g0;
    in_blue_first = p.b0;
    in_red_second = p.r1;
    in_green_second = p.g1;
    in_blue_second = p.b1;
    do @(posedge clk); while (!in_ready);
    predict_pixels(p);
    if (has_exp && p.req) begin
      pixel_q[pixel_q.size()-2].r = ex0;
      pixel_q[pixel_q.size()-2].g = ex0;
      pixel_q[pixel_q.size()-2].b = ex0;
      pixel_q[pixel_q.size()-1].r = ex1;
      pixel_q[pixel_q.size()-1].g = ex1;
      pixel_q[pixel_q.size()-1].b = ex1;
    end
    @(negedge clk);
    if (burst_left == 0) in_valid = 1'b0;
  endtask

  function automatic pair_t rand_pair(input logic req);
    pair_t p;
    p.req = req;
    p.y0 = 16'($urandom); p.y1 = 16'($urandom);
    p.cb = 8'($urandom); p.cr = 8'($urandom);
    p.r0 = 8'($urandom); p.g0 = 8'($urandom); p.b0 = 8'($urandom);
    p.r1 = 8'($urandom); p.g1 = 8'($urandom); p.b1 = 8'($urandom);
    return p;
  endfunction

  function automatic pair_t mk(logic req, logic [15:0] y0, logic [15:0] y1,
                               logic [7:0] cb, logic [7:0] cr, logic [7:0] b0,
                               logic [7:0] b1);
    pair_t p;
    p = rand_pair(req);
    p.y0 = y0; p.y1 = y1; p.cb = cb; p.cr = cr; p.b0 = b0; p.b1 = b1;
    return p;
  endfunction

  // output checker
  always @(posedge clk) begin
    cpfc_pix_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pixel_index, out_red, out_green, out_blue, out_snap_red,
              out_snap_green, out_snap_blue, out_snap_sample, out_frame_last};
      if (pixel_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel idx=%0d", out_pixel_index);
      end else begin
        want = pixel_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("pixel mismatch exp idx=%0d rgb=%h/%h/%h snap=%h/%h/%h s=%h l=%b\n",
                     want.idx, want.r, want.g, want.b, want.sr, want.sg, want.sb,
                     want.samp, want.last,
                     "               got idx=%0d rgb=%h/%h/%h snap=%h/%h/%h s=%h l=%b",
                     got.idx, got.r, got.g, got.b, got.sr, got.sg, got.sb,
                     got.samp, got.last);
        end
      end
    end
  end

  // output side stalls
  initial begin
    int hold, mode, mode_left;
    hold = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold > 0) begin
        hold--;
        out_ready = 1'b0;
      end else begin
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = ($urandom_range(0, 9) < 7);
          default: out_ready = (mode_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    drow_t rows[$];
    drow_t r;
    int unsigned pairs, sent;
    logic [15:0] samples[$];
    logic [1:0] f;
    logic [12:0] w, h;
    bit first;
    pair_t p;

    rows = '{
      '{FMT_RGB32, 0, 640, 480, mk(1, 0, 0, 0, 0, 8'hFF, 8'hFF), 1, 8'hFF, 8'hFF},
      '{FMT_RGB32, 0, 640, 480, mk(1, 0, 0, 0, 0, 8'h00, 8'h00), 1, 8'h00, 8'h00},
      '{FMT_YUY2, 0, 4, 2, mk(1, 16'h00FF, 16'hFFFF, 128, 128, 0, 0), 1, 8'hFF, 8'hFF},
      '{FMT_YUY2, 0, 4, 2, mk(1, 16'hFF00, 16'h0000, 128, 128, 0, 0), 1, 8'h00, 8'h00},
      '{FMT_YUY2, 0, 4, 2, mk(1, 16'h1280, 16'h80FF, 0, 255, 0, 0), 0, 0, 0},
      '{FMT_YUY2, 0, 4, 2, mk(1, 16'h0000, 16'h00FF, 255, 0, 0, 0), 0, 0, 0},
      '{FMT_NV12, 0, 4, 2, mk(1, 16'h00FF, 16'h0000, 255, 255, 0, 0), 0, 0, 0},
      '{FMT_NV12, 0, 4, 2, mk(1, 16'h0000, 16'h00FF, 0, 0, 0, 0), 0, 0, 0},
      '{FMT_NV12, 1, 5, 0, mk(1, 16'h0040, 16'h00C0, 90, 200, 0, 0), 0, 0, 0},
      '{FMT_NV12, 1, 1, 1, mk(1, 16'h0070, 16'h0010, 30, 60, 0, 0), 0, 0, 0},
      '{FMT_Y16, 0, 4, 1, mk(1, 16'h1234, 16'h0000, 0, 0, 0, 0), 1, 8'h00, 8'h00},
      '{FMT_Y16, 0, 4, 1, mk(1, 16'hFFFF, 16'hFFFE, 0, 0, 0, 0), 1, 8'h00, 8'h00},
      '{FMT_Y16, 0, 4, 1, mk(0, 100, 200, 0, 0, 0, 0), 0, 0, 0},
      '{FMT_Y16, 0, 4, 1, mk(0, 300, 150, 0, 0, 0, 0), 0, 0, 0},
      '{FMT_Y16, 0, 4, 1, mk(1, 100, 300, 0, 0, 0, 0), 1, 8'h00, 8'hFF},
      '{FMT_Y16, 0, 4, 1, mk(1, 50, 16'hFFFF, 0, 0, 0, 0), 1, 8'h00, 8'hFF},
      '{FMT_Y16, 1, 4, 1, mk(0, 500, 500, 0, 0, 0, 0), 0, 0, 0},
      '{FMT_Y16, 1, 4, 1, mk(0, 500, 500, 0, 0, 0, 0), 0, 0, 0},
      '{FMT_Y16, 1, 4, 1, mk(1, 501, 500, 0, 0, 0, 0), 1, 8'hFF, 8'h00},
      '{FMT_RGB32, 0, 4, 1, mk(0, 16'hFFFF, 0, 0, 0, 0, 0), 0, 0, 0},
      '{FMT_RGB32, 0, 4, 1, mk(1, 0, 0, 0, 0, 8'h5A, 8'hA5), 1, 8'h5A, 8'hA5},
      '{FMT_RGB32, 1, 8191, 8191, mk(1, 0, 0, 0, 0, 8'h33, 8'h44), 0, 0, 0},
      '{FMT_RGB32, 0, 4096, 4096, mk(1, 0, 0, 0, 0, 8'h12, 8'h34), 0, 0, 0},
      '{FMT_RGB32, 0, 0, 0, mk(1, 0, 0, 0, 0, 8'h01, 8'h02), 0, 0, 0},
      '{FMT_RGB32, 0, 0, 0, mk(1, 0, 0, 0, 0, 8'hFE, 8'h7F), 0, 0, 0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    first = 1;
    foreach (rows[i]) begin
      r = rows[i];
      if (first || r.fmt != p_fmt || r.mir != p_mir || r.w != p_fw || r.h != p_fh) begin
        in_valid = 1'b0;
        burst_left = 0;
        wait_drained();
        set_mode(r.fmt, r.mir, r.w, r.h);
        first = 0;
      end
      send_pair(r.p, r.has_exp, r.ex0, r.ex1);
    end

    for (int ph = 0; ph < 12; ph++) begin
      in_valid = 1'b0;
      burst_left = 0;
      wait_drained();
      f = 2'(ph % 4);
      w = 13'($urandom_range(0, 20));
      h = 13'($urandom_range(0, 5));
      if (ph == 6) begin
        w = 4096;
        h = 4096;
      end else if (ph == 10) begin
        w = 8191;
        h = 8191;
      end
      set_mode(f, 1'($urandom_range(0, 1)), w, h);
      if (ph == 2) hold_req = 1'b1;
      sent = 0;
      if (f == FMT_Y16) begin
        // scan frame then convert frame, with some stray items between
        while (sent < PHASE_ITEMS) begin
          if ($urandom_range(0, 7) == 0) begin
            send_pair(rand_pair(1'($urandom_range(0, 1))));
            sent++;
          end else begin
            pairs = (active_width() / 2) * active_height() - (p_col / 2);
            if (p_row != 0) pairs = 1;
            samples.delete();
            for (int k = 0; k < 2 * pairs; k++)
              samples.push_back(16'(($urandom_range(0, 1)) ? $urandom
                                                            : $urandom_range(0, 40)));
            for (int k = 0; k < pairs; k++) begin
              p = rand_pair(0);
              p.y0 = samples[2*k];
              p.y1 = samples[2*k+1];
              send_pair(p);
            end
            for (int k = 0; k < pairs; k++) begin
              p = rand_pair(1);
              if ($urandom_range(0, 5) != 0) begin
                p.y0 = samples[2*k];
                p.y1 = samples[2*k+1];
              end
              send_pair(p);
            end
            sent += 2 * pairs;
          end
        end
      end else begin
        while (sent < PHASE_ITEMS) begin
          send_pair(rand_pair($urandom_range(0, 7) != 0));
          sent++;
        end
      end
    end

    in_valid = 1'b0;
    wait_drained();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
src/cpfc_pkg.sv
src/cpfc_front.sv
src/cpfc_div.sv
src/cpfc_back.sv
src/camera_pixel_format_converter.sv
test/camera_pixel_format_converter_tb.sv
